// File: hdl/ilff_pkg.sv
// Package for the first-fit heap allocator: sizes, codes and the heap image after reset.
// Depends on nothing; used by implicit_list_first_fit_allocator_top and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package ilff_pkg;

    localparam int HEAP_BYTES  = 65536;
    localparam int CHUNK_BYTES = 4096;
    localparam int WORD_COUNT  = HEAP_BYTES / 4;
    localparam int WIDX_W      = $clog2(WORD_COUNT);
    localparam int ADDR_W      = 64;
    localparam int TAG_W       = 32;
    localparam int BRK_W       = $clog2(HEAP_BYTES + 1);

    // Initial free block, rounded to an even word count.
    localparam int INIT_S   = ((CHUNK_BYTES / 4) + ((CHUNK_BYTES / 4) % 2)) * 4;
    localparam bit INIT_OK  = (16 + INIT_S) <= HEAP_BYTES;
    localparam int FOOT_IDX = (8 + INIT_S) / 4;
    localparam int EPI_IDX  = (12 + INIT_S) / 4;
    localparam int BRK_RST  = INIT_OK ? (16 + INIT_S) : 16;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Heap word after reset: prologue, one free chunk, epilogue.
    function automatic logic [TAG_W-1:0] init_word(input logic [WIDX_W-1:0] i);
        logic [TAG_W-1:0] v;
        v = '0;
        if (i == WIDX_W'(1) || i == WIDX_W'(2)) begin
            v = TAG_W'(9);
        end else if (i == WIDX_W'(3)) begin
            v = INIT_OK ? TAG_W'(INIT_S) : TAG_W'(1);
        end else if (INIT_OK && i == WIDX_W'(FOOT_IDX)) begin
            v = TAG_W'(INIT_S);
        end else if (INIT_OK && i == WIDX_W'(EPI_IDX)) begin
            v = TAG_W'(1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ilff_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Generic; depends on no package.
`timescale 1ns / 1ps
`default_nettype none

module ilff_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/implicit_list_first_fit_allocator_top.sv
// Top level of the first-fit boundary-tag heap allocator: sequencer and tag arithmetic.
// Depends on ilff_pkg and ilff_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A request word (req_type, req_size, block_addr) is taken on in_valid and in_ready.
// One result word (status, result_addr, granted_size) follows on out_valid/out_ready.
// A sequencer drives the heap memory's write port and registered read port; every tag
// read is issued in one step and its data used in the next. A null request or a free
// of address zero goes straight to the finish step, a free runs the merge steps, and an
// allocate walks the blocks in order and places the block, splitting it when enough is
// left. Growing the heap writes the new block and merges it before the placing; when the
// heap cannot grow the result is out of memory. The finish step returns to idle.
// One request is in work at a time; in_ready is high only while the sequencer is idle.
// After reset a clearing pass writes the reset heap image, one word a cycle, over all
// 16384 words (the word count), with in_ready low.
// A finished result sits in an output register; the next request is accepted
// while it waits. If the receiver still stalls when the next result is ready, the
// sequencer holds that result until the output register frees.
module implicit_list_first_fit_allocator_top
    import ilff_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [15:0] req_size,
    input  wire logic [15:0] block_addr,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [15:0]      result_addr,
    output logic [15:0]      granted_size
);

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_FR_A, S_FR_B, S_FR_C,
        S_MG_0, S_MG_1, S_MG_2, S_MG_3, S_MG_4, S_MG_5,
        S_MA_W, S_MA_R, S_MA_F,
        S_MB_W, S_MB_R, S_MB_H, S_MB_R2, S_MB_E,
        S_MC_1, S_MC_R, S_MC_N, S_MC_F,
        S_FF_RD, S_FF_CHK, S_GR_W1, S_GR_W2, S_GR_W3,
        S_PB_RD, S_PB_C, S_PB_R, S_PB_F, S_PB_R2, S_PB_N, S_PB_R3, S_PB_NF,
        S_FIN
    } state_t;

    state_t              state_reg;
    logic [WIDX_W-1:0]   clr_reg;
    logic [ADDR_W-1:0]   bp_reg;
    logic [ADDR_W-1:0]   p_reg;
    logic [ADDR_W-1:0]   n_reg;
    logic [TAG_W-1:0]    s_reg;
    logic [TAG_W-1:0]    psz_reg;
    logic [TAG_W-1:0]    asize_reg;
    logic [TAG_W-1:0]    c_reg;
    logic                pa_reg;
    logic                split_reg;
    logic                put_reg;
    logic [BRK_W-1:0]    brk_reg;
    logic [1:0]          res_status_reg;
    logic [15:0]         res_addr_reg;
    logic [15:0]         res_size_reg;
    logic                rd_ok_reg;
    logic                out_valid_reg;
    logic [1:0]          status_reg;
    logic [15:0]         result_addr_reg;
    logic [15:0]         granted_size_reg;

    logic [ADDR_W-1:0]   rd_a;
    logic [ADDR_W-1:0]   wr_a;
    logic [TAG_W-1:0]    wr_d;
    logic                wr_en;
    logic [TAG_W-1:0]    ram_q;
    logic [TAG_W-1:0]    q;
    logic [ADDR_W-1:0]   qtag;
    logic [TAG_W-1:0]    qsz;
    logic                fits;
    logic [TAG_W-1:0]    ext;
    logic [TAG_W-1:0]    sg;
    logic                grow_fail;
    logic                mg_neither;
    state_t              mg_done;
    logic                rd_in;
    logic                wr_in;

    // Read data; an access outside the store reads as zero.
    assign q    = rd_ok_reg ? ram_q : '0;
    assign qsz  = {q[TAG_W-1:3], 3'b000};
    assign qtag = ADDR_W'(qsz);
    assign fits = (qsz >= asize_reg) && ((qsz - asize_reg) >= TAG_W'(16));

    // Growth amount: larger of request and chunk, rounded to an even word count.
    assign ext = (asize_reg > TAG_W'(CHUNK_BYTES)) ? asize_reg : TAG_W'(CHUNK_BYTES);
    assign sg  = {(ext[TAG_W-1:2] + {{(TAG_W-3){1'b0}}, ext[2]}), 2'b00}
                 & {{(TAG_W-2){1'b1}}, 2'b00};
    assign grow_fail = (TAG_W'(brk_reg) + sg) > TAG_W'(HEAP_BYTES);

    assign mg_neither = !pa_reg && !q[0];
    assign mg_done    = put_reg ? S_PB_RD : S_FIN;

    assign rd_in = rd_a[ADDR_W-1:2] < (ADDR_W-2)'(WORD_COUNT);
    assign wr_in = wr_a[ADDR_W-1:2] < (ADDR_W-2)'(WORD_COUNT);

    // Memory port addressing per sequencer step.
    always_comb
    begin
        rd_a  = '0;
        wr_a  = '0;
        wr_d  = '0;
        wr_en = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                wr_en = 1'b1;
                wr_a  = ADDR_W'({clr_reg, 2'b00});
                wr_d  = init_word(clr_reg);
            end
            S_FR_A, S_MG_3, S_MA_R, S_MC_R, S_PB_RD, S_PB_R, S_PB_R2:
            begin
                rd_a = bp_reg - ADDR_W'(4);
            end
            S_FR_B:
            begin
                wr_en = 1'b1;
                wr_a  = bp_reg - ADDR_W'(4);
                wr_d  = qsz;
            end
            S_FR_C:
            begin
                wr_en = 1'b1;
                wr_a  = bp_reg + ADDR_W'(s_reg) - ADDR_W'(8);
                wr_d  = s_reg;
            end
            S_MG_0, S_MB_R, S_MB_R2:
            begin
                rd_a = bp_reg - ADDR_W'(8);
            end
            S_MG_1:
            begin
                rd_a = bp_reg - qtag - ADDR_W'(4);
            end
            S_MG_2:
            begin
                rd_a = p_reg + qtag - ADDR_W'(8);
            end
            S_MG_4, S_MC_N:
            begin
                rd_a = bp_reg + qtag - ADDR_W'(4);
            end
            S_MG_5:
            begin
                rd_a = n_reg + qtag - ADDR_W'(8);
            end
            S_MA_W, S_GR_W1:
            begin
                wr_en = 1'b1;
                wr_a  = bp_reg - ADDR_W'(4);
                wr_d  = s_reg;
            end
            S_MA_F:
            begin
                wr_en = 1'b1;
                wr_a  = bp_reg + qtag - ADDR_W'(8);
                wr_d  = s_reg;
            end
            S_MB_W:
            begin
                wr_en = 1'b1;
                wr_a  = n_reg - ADDR_W'(8);
                wr_d  = s_reg;
            end
            S_MB_H:
            begin
                wr_en = 1'b1;
                wr_a  = bp_reg - qtag - ADDR_W'(4);
                wr_d  = s_reg;
            end
            S_MC_1:
            begin
                wr_en = 1'b1;
                wr_a  = p_reg - ADDR_W'(4);
                wr_d  = s_reg + qsz;
            end
            S_MC_F:
            begin
                wr_en = 1'b1;
                wr_a  = n_reg + qtag - ADDR_W'(8);
                wr_d  = s_reg;
            end
            S_FF_RD:
            begin
                rd_a = bp_reg - ADDR_W'(4);
            end
            S_GR_W2:
            begin
                wr_en = 1'b1;
                wr_a  = bp_reg + ADDR_W'(s_reg) - ADDR_W'(8);
                wr_d  = s_reg;
            end
            S_GR_W3:
            begin
                wr_en = 1'b1;
                wr_a  = bp_reg + ADDR_W'(s_reg) - ADDR_W'(4);
                wr_d  = TAG_W'(1);
            end
            S_PB_C:
            begin
                wr_en = 1'b1;
                wr_a  = bp_reg - ADDR_W'(4);
                wr_d  = fits ? (asize_reg | TAG_W'(1)) : (qsz | TAG_W'(1));
            end
            S_PB_F:
            begin
                wr_en = 1'b1;
                wr_a  = bp_reg + qtag - ADDR_W'(8);
                wr_d  = split_reg ? (asize_reg | TAG_W'(1)) : (c_reg | TAG_W'(1));
            end
            S_PB_N:
            begin
                wr_en = 1'b1;
                wr_a  = bp_reg + qtag - ADDR_W'(4);
                wr_d  = c_reg - asize_reg;
            end
            S_PB_R3:
            begin
                rd_a = n_reg - ADDR_W'(4);
            end
            S_PB_NF:
            begin
                wr_en = 1'b1;
                wr_a  = n_reg + qtag - ADDR_W'(8);
                wr_d  = c_reg - asize_reg;
            end
            default:
            begin
                rd_a = '0;
            end
        endcase
    end

    ilff_ram #(
        .DEPTH (WORD_COUNT),
        .WIDTH (TAG_W)
    ) u_heap (
        .clk   (clk),
        .we    (wr_en && wr_in),
        .waddr (wr_a[WIDX_W+1:2]),
        .wdata (wr_d),
        .raddr (rd_a[WIDX_W+1:2]),
        .rdata (ram_q)
    );

    // Sequencer, working registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            brk_reg       <= BRK_W'(BRK_RST);
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= rd_in;
            // The finish step loads the output register itself.
            if (out_valid_reg && out_ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + WIDX_W'(1);
                    if (clr_reg == WIDX_W'(WORD_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        res_status_reg <= ST_DONE;
                        res_addr_reg   <= '0;
                        res_size_reg   <= '0;
                        if (req_type == REQ_FREE)
                        begin
                            put_reg   <= 1'b0;
                            bp_reg    <= ADDR_W'(block_addr);
                            state_reg <= (block_addr != 16'd0) ? S_FR_A : S_FIN;
                        end
                        else if (req_size == 16'd0)
                        begin
                            res_status_reg <= ST_NULL;
                            state_reg      <= S_FIN;
                        end
                        else
                        begin
                            put_reg   <= 1'b1;
                            bp_reg    <= ADDR_W'(8);
                            asize_reg <= (req_size <= 16'd8) ? TAG_W'(16) :
                                         (TAG_W'(req_size) + TAG_W'(15)) & ~TAG_W'(7);
                            state_reg <= S_FF_RD;
                        end
                    end
                end
                S_FR_A: state_reg <= S_FR_B;
                S_FR_B:
                begin
                    s_reg     <= qsz;
                    state_reg <= S_FR_C;
                end
                S_FR_C: state_reg <= S_MG_0;
                S_MG_0: state_reg <= S_MG_1;
                S_MG_1:
                begin
                    p_reg     <= bp_reg - qtag;
                    state_reg <= S_MG_2;
                end
                S_MG_2:
                begin
                    psz_reg   <= qsz;
                    state_reg <= S_MG_3;
                end
                S_MG_3:
                begin
                    pa_reg    <= q[0];
                    state_reg <= S_MG_4;
                end
                S_MG_4:
                begin
                    s_reg     <= qsz;
                    n_reg     <= bp_reg + qtag;
                    state_reg <= S_MG_5;
                end
                // Four merge cases: neither, next only, previous only, both free.
                S_MG_5:
                begin
                    priority if (pa_reg && q[0])
                    begin
                        state_reg <= mg_done;
                    end
                    else if (pa_reg)
                    begin
                        s_reg     <= s_reg + qsz;
                        state_reg <= S_MA_W;
                    end
                    else if (q[0])
                    begin
                        s_reg     <= s_reg + psz_reg;
                        state_reg <= S_MB_W;
                    end
                    else
                    begin
                        s_reg     <= s_reg + psz_reg;
                        state_reg <= mg_neither ? S_MC_1 : S_MC_1;
                    end
                end
                S_MA_W: state_reg <= S_MA_R;
                S_MA_R: state_reg <= S_MA_F;
                S_MA_F: state_reg <= mg_done;
                S_MB_W: state_reg <= S_MB_R;
                S_MB_R: state_reg <= S_MB_H;
                S_MB_H: state_reg <= S_MB_R2;
                S_MB_R2: state_reg <= S_MB_E;
                S_MB_E:
                begin
                    bp_reg    <= bp_reg - qtag;
                    state_reg <= mg_done;
                end
                S_MC_1:
                begin
                    s_reg     <= s_reg + qsz;
                    state_reg <= S_MC_R;
                end
                S_MC_R: state_reg <= S_MC_N;
                S_MC_N:
                begin
                    n_reg     <= bp_reg + qtag;
                    state_reg <= S_MC_F;
                end
                S_MC_F: state_reg <= S_MB_R2;
                // First-fit walk, and heap growth when it runs out.
                S_FF_RD, S_FF_CHK:
                begin
                    if ((state_reg == S_FF_RD && bp_reg >= ADDR_W'(brk_reg)) ||
                        (state_reg == S_FF_CHK && qsz == '0))
                    begin
                        if (grow_fail)
                        begin
                            res_status_reg <= ST_OOM;
                            state_reg      <= S_FIN;
                        end
                        else
                        begin
                            bp_reg    <= ADDR_W'(brk_reg);
                            brk_reg   <= brk_reg + BRK_W'(sg);
                            s_reg     <= sg;
                            state_reg <= S_GR_W1;
                        end
                    end
                    else if (state_reg == S_FF_RD)
                    begin
                        state_reg <= S_FF_CHK;
                    end
                    else if (!q[0] && asize_reg <= qsz)
                    begin
                        state_reg <= S_PB_RD;
                    end
                    else
                    begin
                        bp_reg    <= bp_reg + qtag;
                        state_reg <= S_FF_RD;
                    end
                end
                S_GR_W1: state_reg <= S_GR_W2;
                S_GR_W2: state_reg <= S_GR_W3;
                S_GR_W3: state_reg <= S_MG_0;
                // Place the block, splitting off the remainder when it is large enough.
                S_PB_RD: state_reg <= S_PB_C;
                S_PB_C:
                begin
                    c_reg     <= qsz;
                    split_reg <= fits;
                    state_reg <= S_PB_R;
                end
                S_PB_R: state_reg <= S_PB_F;
                S_PB_F:
                begin
                    res_addr_reg <= bp_reg[15:0];
                    res_size_reg <= c_reg[15:0];
                    state_reg    <= split_reg ? S_PB_R2 : S_FIN;
                end
                S_PB_R2: state_reg <= S_PB_N;
                S_PB_N:
                begin
                    n_reg     <= bp_reg + qtag;
                    state_reg <= S_PB_R3;
                end
                S_PB_R3: state_reg <= S_PB_NF;
                S_PB_NF:
                begin
                    res_size_reg <= asize_reg[15:0];
                    state_reg    <= S_FIN;
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        status_reg       <= res_status_reg;
                        result_addr_reg  <= res_addr_reg;
                        granted_size_reg <= res_size_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_addr  = result_addr_reg;
    assign granted_size = granted_size_reg;

    // The heap break stays within the store and never shrinks.
    a_brk_cap: assert property (@(posedge clk) disable iff (!rst_n)
        BRK_W'(brk_reg) <= BRK_W'(HEAP_BYTES))
        else $error("heap break beyond capacity");

    a_brk_mono: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CLR |=> brk_reg >= $past(brk_reg))
        else $error("heap break decreased");

    // An accepted request always leaves the idle state, so in_ready is low in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted without work");

    // A result word never carries an undefined status code.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_DONE || status == ST_NULL || status == ST_OOM))
        else $error("bad status code");

endmodule

`default_nettype wire

// File: dv/implicit_list_first_fit_allocator_top_tb.sv
// Testbench for the first-fit boundary-tag heap allocator: it predicts every result with its
// own heap image and compares field by field. Depends on ilff_pkg and the allocator top level.
`timescale 1ns / 1ps

module implicit_list_first_fit_allocator_top_tb;
    import ilff_pkg::*;

    typedef longint unsigned u64;

    typedef struct {
        logic        kind;
        logic [15:0] size;
        logic [15:0] addr;
    } req_word_t;

    typedef struct {
        logic [1:0]  st;
        logic [15:0] addr;
        logic [15:0] granted;
    } rsp_word_t;

    localparam int RAND_ITEMS = 1330;
    localparam int NOISE_FROM = 1260;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [15:0] req_size;
    logic [15:0] block_addr;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] result_addr;
    logic [15:0] granted_size;

    req_word_t   pending_reqs[$];
    rsp_word_t   expected_rsps[$];
    logic [15:0] live_blocks[$];
    int          total_reqs;
    int          sent_reqs;
    int          errors;
    logic        in_fire;
    int          hold_left;
    bit          held_once;

    // Shadow heap used to work out each expected result.
    logic [31:0] shadow_heap[WORD_COUNT];
    u64          shadow_brk;

    implicit_list_first_fit_allocator_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .req_size(req_size), .block_addr(block_addr),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_addr(result_addr), .granted_size(granted_size)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] heap_rd(u64 a);
        u64 i;
        i = a >> 2;
        return (i < u64'(WORD_COUNT)) ? shadow_heap[i] : 32'd0;
    endfunction

    function automatic void heap_wr(u64 a, logic [31:0] v);
        u64 i;
        i = a >> 2;
        if (i < u64'(WORD_COUNT))
        begin
            shadow_heap[i] = v;
        end
    endfunction

    function automatic logic [31:0] sz_at(u64 a);
        return heap_rd(a) & ~32'd7;
    endfunction

    function automatic logic used_at(u64 a);
        logic [31:0] w;
        w = heap_rd(a);
        return w[0];
    endfunction

    function automatic u64 foot_addr(u64 bp);
        return bp + u64'(sz_at(bp - 4)) - 8;
    endfunction

    function automatic u64 next_bp(u64 bp);
        return bp + u64'(sz_at(bp - 4));
    endfunction

    function automatic u64 prev_bp(u64 bp);
        return bp - u64'(sz_at(bp - 8));
    endfunction

    // Merges a free block with free neighbors; returns the merged block.
    function automatic u64 coalesce(u64 bp);
        logic        pa;
        logic        na;
        logic [31:0] s;
        pa = used_at(foot_addr(prev_bp(bp)));
        na = used_at(next_bp(bp) - 4);
        s = sz_at(bp - 4);
        if (pa && na)
        begin
            return bp;
        end
        if (pa)
        begin
            s = s + sz_at(next_bp(bp) - 4);
            heap_wr(bp - 4, s);
            heap_wr(foot_addr(bp), s);
            return bp;
        end
        if (na)
        begin
            s = s + sz_at(prev_bp(bp) - 4);
            heap_wr(foot_addr(bp), s);
            heap_wr(prev_bp(bp) - 4, s);
            return prev_bp(bp);
        end
        s = s + sz_at(prev_bp(bp) - 4) + sz_at(foot_addr(next_bp(bp)));
        heap_wr(prev_bp(bp) - 4, s);
        heap_wr(foot_addr(next_bp(bp)), s);
        return prev_bp(bp);
    endfunction

    // Extends the break; returns 0 when the heap is full.
    function automatic u64 grow_shadow_heap(u64 bytes);
        u64 words;
        u64 s;
        u64 bp;
        words = bytes >> 2;
        if (words[0])
        begin
            words++;
        end
        s = words * 4;
        if (shadow_brk + s > u64'(HEAP_BYTES))
        begin
            return 0;
        end
        bp = shadow_brk;
        shadow_brk = shadow_brk + s;
        heap_wr(bp - 4, s[31:0]);
        heap_wr(foot_addr(bp), s[31:0]);
        heap_wr(next_bp(bp) - 4, 32'd1);
        return coalesce(bp);
    endfunction

    function automatic void heap_reset();
        u64 unused;
        foreach (shadow_heap[i])
        begin
            shadow_heap[i] = 32'd0;
        end
        shadow_heap[1] = 32'd9;
        shadow_heap[2] = 32'd9;
        shadow_heap[3] = 32'd1;
        shadow_brk = 16;
        unused = grow_shadow_heap(u64'(CHUNK_BYTES));
    endfunction

    // Applies one request to the shadow heap and gives the expected result.
    function automatic rsp_word_t predict_heap_op(req_word_t rq);
        rsp_word_t   r;
        logic [31:0] asize;
        logic [31:0] c;
        logic [31:0] ext;
        logic [31:0] given;
        u64          bp;
        u64          a;
        r.st = ST_DONE;
        r.addr = '0;
        r.granted = '0;
        if (rq.kind == REQ_FREE)
        begin
            a = u64'(rq.addr);
            if (a != 0)
            begin
                c = sz_at(a - 4);
                heap_wr(a - 4, c);
                heap_wr(foot_addr(a), c);
                bp = coalesce(a);
            end
            return r;
        end
        if (rq.size == 16'd0)
        begin
            r.st = ST_NULL;
            return r;
        end
        asize = (rq.size <= 16'd8) ? 32'd16 : 32'd8 * ((32'(rq.size) + 32'd15) / 32'd8);
        // First-fit walk over the implicit list.
        bp = 8;
        while (1)
        begin
            if (!(bp < shadow_brk && sz_at(bp - 4) > 0))
            begin
                bp = 0;
                break;
            end
            if (!used_at(bp - 4) && asize <= sz_at(bp - 4))
            begin
                break;
            end
            bp = next_bp(bp);
        end
        if (bp == 0)
        begin
            ext = (asize > 32'(CHUNK_BYTES)) ? asize : 32'(CHUNK_BYTES);
            bp = grow_shadow_heap(u64'(ext));
            if (bp == 0)
            begin
                r.st = ST_OOM;
                return r;
            end
        end
        // Place the block, splitting when enough is left over.
        c = sz_at(bp - 4);
        if (c >= asize && c - asize >= 32'd16)
        begin
            heap_wr(bp - 4, asize | 32'd1);
            heap_wr(foot_addr(bp), asize | 32'd1);
            a = next_bp(bp);
            heap_wr(a - 4, c - asize);
            heap_wr(foot_addr(a), c - asize);
            given = asize;
        end
        else
        begin
            heap_wr(bp - 4, c | 32'd1);
            heap_wr(foot_addr(bp), c | 32'd1);
            given = c;
        end
        r.addr = bp[15:0];
        r.granted = given[15:0];
        return r;
    endfunction

    // Queues one request word along with its expected result.
    task automatic queue_req(logic kind, logic [15:0] size, logic [15:0] addr);
        req_word_t rq;
        rsp_word_t r;
        int        k;
        rq.kind = kind;
        rq.size = size;
        rq.addr = addr;
        r = predict_heap_op(rq);
        pending_reqs.push_back(rq);
        expected_rsps.push_back(r);
        if (kind == REQ_ALLOC && r.st == ST_DONE)
        begin
            live_blocks.push_back(r.addr);
        end
        if (kind == REQ_FREE)
        begin
            for (k = 0; k < live_blocks.size(); k++)
            begin
                if (live_blocks[k] == addr)
                begin
                    live_blocks.delete(k);
                    break;
                end
            end
        end
    endtask

    task automatic alloc_req(logic [15:0] size);
        queue_req(REQ_ALLOC, size, 16'($urandom));
    endtask

    task automatic free_req(logic [15:0] addr);
        queue_req(REQ_FREE, 16'($urandom), addr);
    endtask

    function automatic logic [15:0] random_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 83)
        begin
            return 16'($urandom_range(1, 256));
        end
        if (r < 95)
        begin
            return 16'($urandom_range(257, 4200));
        end
        return 16'($urandom);
    endfunction

    // Idle phase follows how far the sender has come.
    function automatic int idle_phase();
        return (total_reqs == 0) ? 0 : (sent_reqs * 4) / total_reqs;
    endfunction

    // Sender: a word stays on the bus until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
        end
    end

    always @(negedge clk)
    begin
        req_word_t rq;
        int        ph;
        bit        idle;
        if (rst_n && !(in_valid && !in_fire))
        begin
            ph = idle_phase();
            idle = (ph == 1 && $urandom_range(0, 99) < 73) ||
                   (ph == 3 && $urandom_range(0, 99) < 23);
            if (pending_reqs.size() > 0 && !idle)
            begin
                rq = pending_reqs.pop_front();
                in_valid <= 1'b1;
                req_type <= rq.kind;
                req_size <= rq.size;
                block_addr <= rq.addr;
                sent_reqs <= sent_reqs + 1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver, with one long hold-off early in the run.
    always @(negedge clk)
    begin
        int ph;
        if (rst_n)
        begin
            ph = idle_phase();
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!held_once && sent_reqs >= 30)
            begin
                out_ready <= 1'b0;
                hold_left <= 400;
                held_once <= 1'b1;
            end
            else if (ph == 2)
            begin
                out_ready <= ($urandom_range(0, 99) >= 73);
            end
            else if (ph == 3)
            begin
                out_ready <= ($urandom_range(0, 99) >= 23);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic note_mismatch(string what, int exp_v, int act_v);
        if (errors < 10)
        begin
            $display("%t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
        end
        errors++;
    endtask

    // Monitor: each result word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        rsp_word_t r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                note_mismatch("unexpected result word, status", -1, status);
            end
            else
            begin
                r = expected_rsps.pop_front();
                if (status !== r.st)
                begin
                    note_mismatch("status", r.st, status);
                end
                if (result_addr !== r.addr)
                begin
                    note_mismatch("result_addr", r.addr, result_addr);
                end
                if (granted_size !== r.granted)
                begin
                    note_mismatch("granted_size", r.granted, granted_size);
                end
            end
        end
    end

    initial
    begin
        #1s;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        int          i;
        int          r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_ALLOC;
        req_size = '0;
        block_addr = '0;
        out_ready = 1'b0;
        total_reqs = 0;
        sent_reqs = 0;
        errors = 0;
        hold_left = 0;
        held_once = 1'b0;
        heap_reset();

        // Directed: size extremes, rounding edges, growth, full heap and every merge case.
        alloc_req(16'd0);
        alloc_req(16'd1);
        alloc_req(16'd8);
        alloc_req(16'd9);
        alloc_req(16'd65535);
        alloc_req(16'd5000);
        alloc_req(16'd4088);
        free_req(16'd0);
        alloc_req(16'd24);
        a = live_blocks[live_blocks.size() - 1];
        alloc_req(16'd24);
        b = live_blocks[live_blocks.size() - 1];
        alloc_req(16'd24);
        c = live_blocks[live_blocks.size() - 1];
        alloc_req(16'd24);
        d = live_blocks[live_blocks.size() - 1];
        alloc_req(16'd40);
        free_req(b);
        free_req(a);
        free_req(c);
        free_req(d);
        alloc_req(16'd100);
        alloc_req(16'd30000);
        alloc_req(16'd40000);
        while (live_blocks.size() > 0)
        begin
            free_req(live_blocks[0]);
        end

        // Random: mostly well-formed alloc/free traffic, then a tail of corrupting frees mixed with allocations.
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (i >= NOISE_FROM)
            begin
                if (r < 40)
                begin
                    free_req(16'($urandom));
                end
                else if (r < 55 && live_blocks.size() > 0)
                begin
                    a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                    free_req(a);
                    free_req(a);
                end
                else
                begin
                    alloc_req(random_size());
                end
            end
            else if (live_blocks.size() > 0 && r < 45)
            begin
                free_req(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
            end
            else if (r < 47)
            begin
                free_req(16'd0);
            end
            else if (r < 49)
            begin
                alloc_req(16'd0);
            end
            else
            begin
                alloc_req(random_size());
            end
        end
        total_reqs = pending_reqs.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain, then allow the last word time to show up.
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_valid)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
